>>> rtl/rmj_pkg.sv
`default_nettype none
package rmj_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned FRAC_W   = 16;
	localparam int unsigned MAG_W    = WORD_W;
	localparam int unsigned SQ_W     = 2 * WORD_W;
	localparam int unsigned ROOT_W   = WORD_W;
	localparam int unsigned SQ_REM_W = WORD_W + 2;
	localparam int unsigned SQ_N     = ROOT_W;
	localparam int unsigned DIV_D_W  = 2 * WORD_W;
	// quotient bound: the rate weight stays below 2^(WORD_W + FRAC_W/2)
	localparam int unsigned DIV_Q_W  = WORD_W + FRAC_W / 2 + 1;
	localparam int unsigned DIV_N    = DIV_Q_W;
	localparam int unsigned NUM_W    = DIV_D_W + DIV_Q_W;
	// px/r and py/r never exceed 1.0
	localparam int unsigned RQ_W     = FRAC_W + 1;
	localparam int unsigned PROD_W   = DIV_Q_W + RQ_W;
	localparam int unsigned CROSS_W  = 2 * WORD_W + 2;
	localparam int unsigned MIN_W    = 17;
	localparam int unsigned THR_W    = MIN_W + FRAC_W;
	localparam int unsigned LATENCY  = 4 + SQ_N + DIV_N + 2;
	localparam int unsigned PADDR_W  = 3;
	localparam int unsigned PDATA_W  = 32;
	localparam int unsigned DIV_LANES = 5;

	localparam logic [MIN_W-1:0]   MIN_RESET         = 17'd66;
	localparam logic [PADDR_W-1:0] ADDR_MIN_SQ_RANGE = 3'd0;

	localparam int unsigned LANE_RX = 0;
	localparam int unsigned LANE_RY = 1;
	localparam int unsigned LANE_BX = 2;
	localparam int unsigned LANE_BY = 3;
	localparam int unsigned LANE_W  = 4;

	typedef struct packed {
		logic [SQ_REM_W-1:0] rem;
		logic [ROOT_W-1:0]   root;
		logic [SQ_W-1:0]     src;
	} sq_cell_t;

	typedef struct packed {
		logic [DIV_D_W-1:0] rem;
		logic [DIV_Q_W-1:0] nq;
		logic [DIV_D_W-1:0] d;
	} dv_cell_t;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              flag;
	} sat_t;

	function automatic logic [MAG_W-1:0] mag_of(input logic [WORD_W-1:0] v);
		return v[WORD_W-1] ? (~v + WORD_W'(1)) : v;
	endfunction

	function automatic sat_t saturate(input logic neg, input logic [DIV_D_W-1:0] mag);
		sat_t res;
		logic [DIV_D_W-1:0] lim;
		lim = DIV_D_W'(1) << (WORD_W - 1);
		res.flag = neg ? (mag > lim) : (mag >= lim);
		if (res.flag) begin
			res.word = neg ? lim[WORD_W-1:0] : (lim[WORD_W-1:0] - WORD_W'(1));
		end else begin
			res.word = neg ? (~mag[WORD_W-1:0] + WORD_W'(1)) : mag[WORD_W-1:0];
		end
		return res;
	endfunction

	function automatic dv_cell_t div_seed(input logic [NUM_W-1:0] num,
			input logic [DIV_D_W-1:0] den);
		dv_cell_t c;
		c.rem = num[NUM_W-1 -: DIV_D_W];
		c.nq  = num[DIV_Q_W-1:0];
		c.d   = den;
		return c;
	endfunction

endpackage
`default_nettype wire

>>> rtl/radar_measurement_jacobian.sv
`default_nettype none
// Radar measurement Jacobian for a constant-velocity state, Q16.16.
// Input: pulse start with pos_x, pos_y, vel_x, vel_y; the word is taken at
// every edge where start is high and busy is low. busy stays low, so a new
// word may enter every cycle.
// Output: done is high for one cycle with the six Jacobian entries and the
// range_clamped and saturated flags. The receiver cannot hold results off.
// Pipeline: the result passes the 4 setup stages, 32 square-root cells,
// 41 divider cells, multiply and saturate before done is sampled high.
// Throughput: one word per cycle; the square-root and divider cell rows
// each retire one bit per cell per cycle.
// Configuration: APB register min_squared_range at byte address 0, written
// while no word is in flight. A value of zero acts as one.
// Reset: arst_n clears the valid line and loads min_squared_range with 66;
// words in flight are dropped.
module radar_measurement_jacobian (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic signed [rmj_pkg::WORD_W-1:0]   pos_x,
	input  wire logic signed [rmj_pkg::WORD_W-1:0]   pos_y,
	input  wire logic signed [rmj_pkg::WORD_W-1:0]   vel_x,
	input  wire logic signed [rmj_pkg::WORD_W-1:0]   vel_y,
	output logic                                     done,
	output logic signed [rmj_pkg::WORD_W-1:0]        range_dx,
	output logic signed [rmj_pkg::WORD_W-1:0]        range_dy,
	output logic signed [rmj_pkg::WORD_W-1:0]        bearing_dx,
	output logic signed [rmj_pkg::WORD_W-1:0]        bearing_dy,
	output logic signed [rmj_pkg::WORD_W-1:0]        rate_dx,
	output logic signed [rmj_pkg::WORD_W-1:0]        rate_dy,
	output logic                                     range_clamped,
	output logic                                     saturated,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [rmj_pkg::PADDR_W-1:0]         paddr,
	input  wire logic [rmj_pkg::PDATA_W-1:0]         pwdata,
	output logic [rmj_pkg::PDATA_W-1:0]              prdata,
	output logic                                     pready
);

	typedef struct packed {
		logic [rmj_pkg::SQ_W-1:0]  s;
		logic [rmj_pkg::MAG_W-1:0] px;
		logic [rmj_pkg::MAG_W-1:0] py;
		logic [rmj_pkg::SQ_W-1:0]  cmag;
		logic                      sx;
		logic                      sy;
		logic                      cneg;
		logic                      clamped;
	} sq_side_t;

	typedef struct packed {
		logic sx;
		logic sy;
		logic cneg;
		logic clamped;
	} dv_side_t;

	// configuration
	logic [rmj_pkg::MIN_W-1:0] min_q;
	logic [rmj_pkg::MIN_W-1:0] min_eff;
	logic                      reg_hit;
	logic                      wr_en;

	assign pready  = 1'b1;
	assign busy    = 1'b0;
	assign reg_hit = paddr[rmj_pkg::PADDR_W-1:2]
		== rmj_pkg::ADDR_MIN_SQ_RANGE[rmj_pkg::PADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready && reg_hit;
	assign prdata  = reg_hit ? rmj_pkg::PDATA_W'(min_q) : '0;
	assign min_eff = (min_q == '0) ? rmj_pkg::MIN_W'(1) : min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= rmj_pkg::MIN_RESET;
		end else if (wr_en) begin
			min_q <= pwdata[rmj_pkg::MIN_W-1:0];
		end
	end

	// valid line
	logic                     v_s1, v_s2, v_s3, v_s4, v_s5, done_q;
	logic [rmj_pkg::SQ_N-1:0]  sq_vld_q;
	logic [rmj_pkg::DIV_N-1:0] dv_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			sq_vld_q <= '0;
			dv_vld_q <= '0;
			v_s5     <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			v_s1     <= start && !busy;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			v_s4     <= v_s3;
			sq_vld_q <= {sq_vld_q[rmj_pkg::SQ_N-2:0], v_s4};
			dv_vld_q <= {dv_vld_q[rmj_pkg::DIV_N-2:0], sq_vld_q[rmj_pkg::SQ_N-1]};
			v_s5     <= dv_vld_q[rmj_pkg::DIV_N-1];
			done_q   <= v_s5;
		end
	end

	// stage 1: sign and magnitude
	logic [rmj_pkg::MAG_W-1:0] px_s1, py_s1, vx_s1, vy_s1;
	logic                      sx_s1, sy_s1, svx_s1, svy_s1;

	always_ff @(posedge clk) begin
		px_s1  <= rmj_pkg::mag_of(pos_x);
		py_s1  <= rmj_pkg::mag_of(pos_y);
		vx_s1  <= rmj_pkg::mag_of(vel_x);
		vy_s1  <= rmj_pkg::mag_of(vel_y);
		sx_s1  <= pos_x[rmj_pkg::WORD_W-1];
		sy_s1  <= pos_y[rmj_pkg::WORD_W-1];
		svx_s1 <= vel_x[rmj_pkg::WORD_W-1];
		svy_s1 <= vel_y[rmj_pkg::WORD_W-1];
	end

	// stage 2: products
	logic [rmj_pkg::SQ_W-1:0]  xx_s2, yy_s2, a_s2, b_s2;
	logic [rmj_pkg::MAG_W-1:0] px_s2, py_s2;
	logic                      na_s2, nb_s2, sx_s2, sy_s2;

	always_ff @(posedge clk) begin
		xx_s2 <= px_s1 * px_s1;
		yy_s2 <= py_s1 * py_s1;
		a_s2  <= vx_s1 * py_s1;
		b_s2  <= vy_s1 * px_s1;
		na_s2 <= svx_s1 ^ sy_s1;
		nb_s2 <= svy_s1 ^ sx_s1;
		px_s2 <= px_s1;
		py_s2 <= py_s1;
		sx_s2 <= sx_s1;
		sy_s2 <= sy_s1;
	end

	// stage 3: squared range and cross term
	logic [rmj_pkg::CROSS_W-1:0] a_ext, b_ext;
	logic [rmj_pkg::SQ_W-1:0]    ss_s3;
	logic [rmj_pkg::CROSS_W-1:0] cross_s3;
	logic [rmj_pkg::MAG_W-1:0]   px_s3, py_s3;
	logic                        sx_s3, sy_s3;

	assign a_ext = na_s2 ? (rmj_pkg::CROSS_W'(0) - rmj_pkg::CROSS_W'(a_s2))
		: rmj_pkg::CROSS_W'(a_s2);
	assign b_ext = nb_s2 ? (rmj_pkg::CROSS_W'(0) - rmj_pkg::CROSS_W'(b_s2))
		: rmj_pkg::CROSS_W'(b_s2);

	always_ff @(posedge clk) begin
		ss_s3    <= xx_s2 + yy_s2;
		cross_s3 <= a_ext - b_ext;
		px_s3    <= px_s2;
		py_s3    <= py_s2;
		sx_s3    <= sx_s2;
		sy_s3    <= sy_s2;
	end

	// stage 4: clamp and cross magnitude
	logic [rmj_pkg::SQ_W-1:0]    thr;
	logic [rmj_pkg::CROSS_W-1:0] cross_neg;
	logic                        clamp_now;
	sq_side_t                    side_s4;

	assign thr       = rmj_pkg::SQ_W'(rmj_pkg::THR_W'(min_eff) << rmj_pkg::FRAC_W);
	assign clamp_now = ss_s3 < thr;
	assign cross_neg = rmj_pkg::CROSS_W'(0) - cross_s3;

	always_ff @(posedge clk) begin
		side_s4.s       <= clamp_now ? thr : ss_s3;
		side_s4.clamped <= clamp_now;
		side_s4.cneg    <= cross_s3[rmj_pkg::CROSS_W-1];
		side_s4.cmag    <= cross_s3[rmj_pkg::CROSS_W-1]
			? cross_neg[rmj_pkg::SQ_W-1:0] : cross_s3[rmj_pkg::SQ_W-1:0];
		side_s4.px      <= px_s3;
		side_s4.py      <= py_s3;
		side_s4.sx      <= sx_s3;
		side_s4.sy      <= sy_s3;
	end

	// square-root row
	rmj_pkg::sq_cell_t sq_link [rmj_pkg::SQ_N+1];
	sq_side_t          sq_side_q [rmj_pkg::SQ_N];

	assign sq_link[0] = '{rem: '0, root: '0, src: side_s4.s};

	for (genvar k = 0; k < rmj_pkg::SQ_N; k++) begin : g_sq
		rmj_sqrt_cell u_cell (
			.clk      (clk),
			.src_cell (sq_link[k]),
			.dst_cell (sq_link[k+1])
		);
	end

	always_ff @(posedge clk) begin
		sq_side_q[0] <= side_s4;
		for (int k = 1; k < rmj_pkg::SQ_N; k++) begin
			sq_side_q[k] <= sq_side_q[k-1];
		end
	end

	// divider rows
	sq_side_t                  sqo;
	logic [rmj_pkg::ROOT_W-1:0] root;
	rmj_pkg::dv_cell_t         dv_link [rmj_pkg::DIV_LANES][rmj_pkg::DIV_N+1];
	dv_side_t                  dv_side_q [rmj_pkg::DIV_N];

	assign sqo  = sq_side_q[rmj_pkg::SQ_N-1];
	assign root = sq_link[rmj_pkg::SQ_N].root;

	assign dv_link[rmj_pkg::LANE_RX][0] = rmj_pkg::div_seed(
		rmj_pkg::NUM_W'(sqo.px) << rmj_pkg::FRAC_W, rmj_pkg::DIV_D_W'(root));
	assign dv_link[rmj_pkg::LANE_RY][0] = rmj_pkg::div_seed(
		rmj_pkg::NUM_W'(sqo.py) << rmj_pkg::FRAC_W, rmj_pkg::DIV_D_W'(root));
	assign dv_link[rmj_pkg::LANE_BX][0] = rmj_pkg::div_seed(
		rmj_pkg::NUM_W'(sqo.py) << (2 * rmj_pkg::FRAC_W), sqo.s);
	assign dv_link[rmj_pkg::LANE_BY][0] = rmj_pkg::div_seed(
		rmj_pkg::NUM_W'(sqo.px) << (2 * rmj_pkg::FRAC_W), sqo.s);
	assign dv_link[rmj_pkg::LANE_W][0] = rmj_pkg::div_seed(
		rmj_pkg::NUM_W'(sqo.cmag) << rmj_pkg::FRAC_W, sqo.s);

	for (genvar l = 0; l < rmj_pkg::DIV_LANES; l++) begin : g_lane
		for (genvar k = 0; k < rmj_pkg::DIV_N; k++) begin : g_dv
			rmj_div_cell u_cell (
				.clk      (clk),
				.src_cell (dv_link[l][k]),
				.dst_cell (dv_link[l][k+1])
			);
		end
	end

	always_ff @(posedge clk) begin
		dv_side_q[0] <= '{sx: sqo.sx, sy: sqo.sy, cneg: sqo.cneg, clamped: sqo.clamped};
		for (int k = 1; k < rmj_pkg::DIV_N; k++) begin
			dv_side_q[k] <= dv_side_q[k-1];
		end
	end

	// stage 5: rate products
	logic [rmj_pkg::DIV_Q_W-1:0] q_rx, q_ry, q_bx, q_by, q_w;
	logic [rmj_pkg::PROD_W-1:0]  ratex_s5, ratey_s5;
	logic [rmj_pkg::DIV_Q_W-1:0] rx_s5, ry_s5, bx_s5, by_s5;
	dv_side_t                    side_s5;

	assign q_rx = dv_link[rmj_pkg::LANE_RX][rmj_pkg::DIV_N].nq;
	assign q_ry = dv_link[rmj_pkg::LANE_RY][rmj_pkg::DIV_N].nq;
	assign q_bx = dv_link[rmj_pkg::LANE_BX][rmj_pkg::DIV_N].nq;
	assign q_by = dv_link[rmj_pkg::LANE_BY][rmj_pkg::DIV_N].nq;
	assign q_w  = dv_link[rmj_pkg::LANE_W][rmj_pkg::DIV_N].nq;

	always_ff @(posedge clk) begin
		ratex_s5 <= q_w * q_ry[rmj_pkg::RQ_W-1:0];
		ratey_s5 <= q_w * q_rx[rmj_pkg::RQ_W-1:0];
		rx_s5    <= q_rx;
		ry_s5    <= q_ry;
		bx_s5    <= q_bx;
		by_s5    <= q_by;
		side_s5  <= dv_side_q[rmj_pkg::DIV_N-1];
	end

	// output stage: sign, saturate, flags
	rmj_pkg::sat_t sat_rx, sat_ry, sat_bx, sat_by, sat_tx, sat_ty;
	logic [rmj_pkg::PROD_W-1:0] ratex_sh, ratey_sh;

	assign ratex_sh = ratex_s5 >> rmj_pkg::FRAC_W;
	assign ratey_sh = ratey_s5 >> rmj_pkg::FRAC_W;
	assign sat_rx = rmj_pkg::saturate(side_s5.sx, rmj_pkg::DIV_D_W'(rx_s5));
	assign sat_ry = rmj_pkg::saturate(side_s5.sy, rmj_pkg::DIV_D_W'(ry_s5));
	assign sat_bx = rmj_pkg::saturate(!side_s5.sy, rmj_pkg::DIV_D_W'(bx_s5));
	assign sat_by = rmj_pkg::saturate(side_s5.sx, rmj_pkg::DIV_D_W'(by_s5));
	assign sat_tx = rmj_pkg::saturate(side_s5.sy ^ side_s5.cneg,
		rmj_pkg::DIV_D_W'(ratex_sh));
	assign sat_ty = rmj_pkg::saturate(!(side_s5.sx ^ side_s5.cneg),
		rmj_pkg::DIV_D_W'(ratey_sh));

	logic [rmj_pkg::WORD_W-1:0] rdx_q, rdy_q, bdx_q, bdy_q, tdx_q, tdy_q;
	logic                       clamped_q, sat_q;

	always_ff @(posedge clk) begin
		rdx_q     <= sat_rx.word;
		rdy_q     <= sat_ry.word;
		bdx_q     <= sat_bx.word;
		bdy_q     <= sat_by.word;
		tdx_q     <= sat_tx.word;
		tdy_q     <= sat_ty.word;
		clamped_q <= side_s5.clamped;
		sat_q     <= sat_rx.flag | sat_ry.flag | sat_bx.flag | sat_by.flag
			| sat_tx.flag | sat_ty.flag;
	end

	assign done          = done_q;
	assign range_dx      = rdx_q;
	assign range_dy      = rdy_q;
	assign bearing_dx    = bdx_q;
	assign bearing_dy    = bdy_q;
	assign rate_dx       = tdx_q;
	assign rate_dy       = tdy_q;
	assign range_clamped = clamped_q;
	assign saturated     = sat_q;

`ifndef SYNTHESIS
	a_start_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(rmj_pkg::LATENCY) done)
		else $error("accepted word produced no result");

	a_done_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, rmj_pkg::LATENCY))
		else $error("result without an accepted word");

	// px/r and py/r never exceed 1.0 in magnitude
	a_range_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rmj_pkg::mag_of(rdx_q) <= (rmj_pkg::MAG_W'(1) << rmj_pkg::FRAC_W)
			&& rmj_pkg::mag_of(rdy_q) <= (rmj_pkg::MAG_W'(1) << rmj_pkg::FRAC_W)))
		else $error("range entry out of bound");
`endif

endmodule
`default_nettype wire

>>> rtl/rmj_sqrt_cell.sv
`default_nettype none
module rmj_sqrt_cell (
	input  wire logic               clk,
	input  wire rmj_pkg::sq_cell_t  src_cell,
	output rmj_pkg::sq_cell_t       dst_cell
);

	logic [rmj_pkg::SQ_REM_W+1:0] part;
	logic [rmj_pkg::SQ_REM_W+1:0] trial;
	logic [rmj_pkg::SQ_REM_W+1:0] diff;
	logic                         ge;
	rmj_pkg::sq_cell_t            cell_q;

	// bring in the next two bits of the radicand, try root bit one
	assign part  = {src_cell.rem, src_cell.src[rmj_pkg::SQ_W-1 -: 2]};
	assign trial = (rmj_pkg::SQ_REM_W+2)'({src_cell.root, 2'b01});
	assign diff  = part - trial;
	assign ge    = part >= trial;

	always_ff @(posedge clk) begin
		cell_q.rem  <= ge ? diff[rmj_pkg::SQ_REM_W-1:0] : part[rmj_pkg::SQ_REM_W-1:0];
		cell_q.root <= {src_cell.root[rmj_pkg::ROOT_W-2:0], ge};
		cell_q.src  <= {src_cell.src[rmj_pkg::SQ_W-3:0], 2'b00};
	end

	assign dst_cell = cell_q;

endmodule
`default_nettype wire

>>> rtl/rmj_div_cell.sv
`default_nettype none
module rmj_div_cell (
	input  wire logic               clk,
	input  wire rmj_pkg::dv_cell_t  src_cell,
	output rmj_pkg::dv_cell_t       dst_cell
);

	logic [rmj_pkg::DIV_D_W:0] part;
	logic [rmj_pkg::DIV_D_W:0] diff;
	logic                      ge;
	rmj_pkg::dv_cell_t         cell_q;

	// shift in the next dividend bit, subtract when it fits
	assign part = {src_cell.rem, src_cell.nq[rmj_pkg::DIV_Q_W-1]};
	assign ge   = part >= {1'b0, src_cell.d};
	assign diff = part - {1'b0, src_cell.d};

	always_ff @(posedge clk) begin
		cell_q.rem <= ge ? diff[rmj_pkg::DIV_D_W-1:0] : part[rmj_pkg::DIV_D_W-1:0];
		cell_q.nq  <= {src_cell.nq[rmj_pkg::DIV_Q_W-2:0], ge};
		cell_q.d   <= src_cell.d;
	end

	assign dst_cell = cell_q;

endmodule
`default_nettype wire

>>> bench/tb.sv
`default_nettype none
module tb;
	import rmj_pkg::*;

	typedef struct packed {
		logic [WORD_W-1:0] px;
		logic [WORD_W-1:0] py;
		logic [WORD_W-1:0] vx;
		logic [WORD_W-1:0] vy;
	} state_word_t;

	typedef struct packed {
		logic [WORD_W-1:0] rdx;
		logic [WORD_W-1:0] rdy;
		logic [WORD_W-1:0] bdx;
		logic [WORD_W-1:0] bdy;
		logic [WORD_W-1:0] tdx;
		logic [WORD_W-1:0] tdy;
		logic              clamped;
		logic              sat;
	} jacobian_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [WORD_W-1:0] pos_x, pos_y, vel_x, vel_y;
	logic done;
	logic signed [WORD_W-1:0] range_dx, range_dy, bearing_dx, bearing_dy, rate_dx, rate_dy;
	logic range_clamped, saturated;
	logic psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	radar_measurement_jacobian i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pos_x(pos_x), .pos_y(pos_y), .vel_x(vel_x), .vel_y(vel_y),
		.done(done), .range_dx(range_dx), .range_dy(range_dy),
		.bearing_dx(bearing_dx), .bearing_dy(bearing_dy),
		.rate_dx(rate_dx), .rate_dy(rate_dy),
		.range_clamped(range_clamped), .saturated(saturated),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	logic [MIN_W-1:0] min_sq;
	state_word_t      pending_words[$];
	jacobian_t        expected_jac[$];
	int               gap_left;
	int               n_fail;
	int               n_checked;
	int               n_clamped;
	int               n_sat;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] magnitude(input logic [WORD_W-1:0] v);
		logic [WORD_W-1:0] m;
		m = v[WORD_W-1] ? (~v + WORD_W'(1)) : v;
		return 64'(m);
	endfunction

	// clip a sign/magnitude pair into a word, flag when clipped
	function automatic logic [WORD_W-1:0] clip(input logic neg, input logic [127:0] mag,
			inout logic flag);
		logic [127:0] lim;
		lim = 128'(1) << (WORD_W - 1);
		if (!neg) begin
			if (mag > lim - 1) begin
				flag = 1'b1;
				return lim[WORD_W-1:0] - 1'b1;
			end
			return mag[WORD_W-1:0];
		end
		if (mag > lim) begin
			flag = 1'b1;
			return lim[WORD_W-1:0];
		end
		return -mag[WORD_W-1:0];
	endfunction

	function automatic jacobian_t jacobian_of(input state_word_t w, input logic [MIN_W-1:0] mn);
		jacobian_t j;
		logic [63:0] mx, my, r, cand;
		logic signed [63:0] pa, pb;
		logic [127:0] s, thr, c, cm, wt, rxm, rym;
		logic nx, ny, cneg, sat;
		sat = 1'b0;
		nx = w.px[WORD_W-1];
		ny = w.py[WORD_W-1];
		mx = magnitude(w.px);
		my = magnitude(w.py);
		s = 128'(mx) * 128'(mx) + 128'(my) * 128'(my);
		thr = 128'(mn == 0 ? 1 : mn) << FRAC_W;
		j.clamped = s < thr;
		if (j.clamped)
			s = thr;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			cand = r | (64'(1) << b);
			if (128'(cand) * 128'(cand) <= s)
				r = cand;
		end
		pa = $signed(w.vx) * $signed(w.py);
		pb = $signed(w.vy) * $signed(w.px);
		c = {{64{pa[63]}}, pa} - {{64{pb[63]}}, pb};
		cneg = c[127];
		cm = cneg ? -c : c;
		wt = (cm << FRAC_W) / s;
		rxm = (128'(mx) << FRAC_W) / 128'(r);
		rym = (128'(my) << FRAC_W) / 128'(r);
		j.rdx = clip(nx, rxm, sat);
		j.rdy = clip(ny, rym, sat);
		j.bdx = clip(!ny, (128'(my) << (2 * FRAC_W)) / s, sat);
		j.bdy = clip(nx, (128'(mx) << (2 * FRAC_W)) / s, sat);
		j.tdx = clip(ny != cneg, (wt * rym[63:0]) >> FRAC_W, sat);
		j.tdy = clip(nx == cneg, (wt * rxm[63:0]) >> FRAC_W, sat);
		j.sat = sat;
		return j;
	endfunction

	// driver: each word draws the idle cycles that follow it
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap_left <= 0;
		end else if (start && busy) begin
			// hold the word until it is taken
			start <= 1'b1;
		end else if (gap_left > 0) begin
			start <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (pending_words.size() > 0) begin
			state_word_t w;
			w = pending_words.pop_front();
			{pos_x, pos_y, vel_x, vel_y} <= w;
			start <= 1'b1;
			gap_left <= $urandom_range(0, 4);
		end else begin
			start <= 1'b0;
		end
	end

	// predict on the accepting edge, check on the strobe
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			expected_jac.push_back(jacobian_of({pos_x, pos_y, vel_x, vel_y}, min_sq));
		if (arst_n && done) begin
			if (expected_jac.size() == 0) begin
				$error("result with no word pending");
				n_fail++;
			end else begin
				jacobian_t e;
				e = expected_jac.pop_front();
				n_checked++;
				n_clamped += e.clamped;
				n_sat += e.sat;
				if (range_dx !== e.rdx) begin
					$error("range_dx exp %h got %h", e.rdx, range_dx); n_fail++;
				end
				if (range_dy !== e.rdy) begin
					$error("range_dy exp %h got %h", e.rdy, range_dy); n_fail++;
				end
				if (bearing_dx !== e.bdx) begin
					$error("bearing_dx exp %h got %h", e.bdx, bearing_dx); n_fail++;
				end
				if (bearing_dy !== e.bdy) begin
					$error("bearing_dy exp %h got %h", e.bdy, bearing_dy); n_fail++;
				end
				if (rate_dx !== e.tdx) begin
					$error("rate_dx exp %h got %h", e.tdx, rate_dx); n_fail++;
				end
				if (rate_dy !== e.tdy) begin
					$error("rate_dy exp %h got %h", e.tdy, rate_dy); n_fail++;
				end
				if (range_clamped !== e.clamped) begin
					$error("range_clamped exp %b got %b", e.clamped, range_clamped); n_fail++;
				end
				if (saturated !== e.sat) begin
					$error("saturated exp %b got %b", e.sat, saturated); n_fail++;
				end
			end
		end
	end

	task automatic write_min(input logic [MIN_W-1:0] v);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= ADDR_MIN_SQ_RANGE;
		pwdata <= PDATA_W'(v);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		min_sq = v;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic drain();
		wait (pending_words.size() == 0);
		@(posedge clk);
		wait (!start && expected_jac.size() == 0);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic [WORD_W-1:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return WORD_W'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
			2: return WORD_W'($signed($urandom_range(0, 255)) - 128);
			default: return WORD_W'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
		endcase
	endfunction

	task automatic random_phase(input int n);
		state_word_t w;
		for (int i = 0; i < n; i++) begin
			w = {rand_coord(), rand_coord(), rand_coord(), rand_coord()};
			pending_words.push_back(w);
		end
	endtask

	localparam logic [WORD_W-1:0] MAXP = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic [WORD_W-1:0] MAXN = {1'b1, {(WORD_W-1){1'b0}}};
	localparam logic [WORD_W-1:0] ONE  = WORD_W'(1) << FRAC_W;

	initial begin
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		min_sq = MIN_RESET;
		n_fail = 0; n_checked = 0; n_clamped = 0; n_sat = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// origin, tiny, extremes, each sign, zero cross, huge cross
		pending_words.push_back({WORD_W'(0), WORD_W'(0), WORD_W'(0), WORD_W'(0)});
		pending_words.push_back({WORD_W'(1), WORD_W'(0), ONE, ONE});
		pending_words.push_back({MAXP, MAXP, MAXP, MAXN});
		pending_words.push_back({MAXN, MAXN, MAXN, MAXP});
		pending_words.push_back({MAXN, WORD_W'(0), MAXP, MAXP});
		pending_words.push_back({WORD_W'(0), MAXP, MAXN, MAXN});
		pending_words.push_back({ONE, ONE, ONE, ONE});
		pending_words.push_back({-ONE, ONE, ONE, -ONE});
		pending_words.push_back({ONE, -ONE, -ONE, ONE});
		pending_words.push_back({-ONE, -ONE, MAXP, MAXN});
		pending_words.push_back({WORD_W'(3), WORD_W'(-5), MAXN, MAXN});
		pending_words.push_back({WORD_W'(200), WORD_W'(-100), MAXP, MAXN});
		pending_words.push_back({WORD_W'(-1), WORD_W'(-1), WORD_W'(-1), WORD_W'(-1)});
		pending_words.push_back({32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF});
		drain();

		// zero behaves as one; max threshold clamps a lot
		write_min('0);
		random_phase(100);
		pending_words.push_back({WORD_W'(0), WORD_W'(0), ONE, ONE});
		drain();
		write_min(17'h10000);
		random_phase(150);
		drain();
		write_min(17'h1FFFF);
		random_phase(100);
		drain();
		write_min(17'd1);
		random_phase(150);
		drain();
		write_min(MIN_RESET);
		random_phase(150);
		drain();

		$display("checked %0d Jacobians across 5 clamp settings; %0d clamped, %0d saturated",
			n_checked, n_clamped, n_sat);
		if (n_fail == 0 && expected_jac.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end
endmodule
`default_nettype wire

>>> files.f
rtl/rmj_pkg.sv
rtl/rmj_sqrt_cell.sv
rtl/rmj_div_cell.sv
rtl/radar_measurement_jacobian.sv
bench/tb.sv
